[hw/rtl/checksummed_xor_frame_codec_core_macros.svh]
// Assertion macros used by the codec RTL (the result register, cxf_out).
`ifndef CHECKSUMMED_XOR_FRAME_CODEC_CORE_MACROS_SVH
`define CHECKSUMMED_XOR_FRAME_CODEC_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CXF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
// next-cycle implication
`define CXF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define CXF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CXF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/cxf_pkg.sv]
// Types and constants of the checksummed XOR frame codec.
package cxf_pkg;

    localparam int KEY_BYTES = 16;
    localparam int POS_W     = 12;
    localparam int CAP_W     = 13;
    localparam int KLEN_W    = 5;

    localparam logic [8:0] FLETCHER_MOD = 9'd255;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MAGIC    = 3'd0;
    localparam t_cfg_idx CFG_KEY_LOW  = 3'd1;
    localparam t_cfg_idx CFG_KEY_HIGH = 3'd2;
    localparam t_cfg_idx CFG_KEY_LEN  = 3'd3;
    localparam t_cfg_idx CFG_CAPACITY = 3'd4;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_SHORT    = 3'd1;
    localparam t_status ST_MAGIC    = 3'd2;
    localparam t_status ST_OVER     = 3'd3;
    localparam t_status ST_CHECKSUM = 3'd4;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 13'd4096;

    typedef struct packed {
        logic [15:0]                 magic;
        logic [KEY_BYTES-1:0][7:0]   key;
        logic [KLEN_W-1:0]           key_length;
        logic [CAP_W-1:0]            capacity;
    } t_cfg;

    typedef struct packed {
        logic             has_byte;
        logic [7:0]       out_byte;
        logic [POS_W-1:0] position;
        logic             run_last;
        t_status          status;
    } t_result;

    // results caused by one input transfer: an optional first result and
    // an optional four-byte encode trailer
    typedef struct packed {
        logic            valid;
        t_result         first;
        logic            tail;
        logic [3:0][7:0] tail_bytes;
        t_status         tail_status;
    } t_bundle;

endpackage

[hw/rtl/cxf_if.sv]
// Valid/ready channel interfaces of the codec.
interface cxf_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source(output valid, mode, data_byte, last_byte, input ready);
    modport sink(input valid, mode, data_byte, last_byte, output ready);
endinterface

interface cxf_out_if;
    logic        valid;
    logic        ready;
    logic        has_byte;
    logic [7:0]  out_byte;
    logic [11:0] position;
    logic        run_last;
    logic [2:0]  status;
    modport source(output valid, has_byte, out_byte, position, run_last, status,
                   input ready);
    modport sink(input valid, has_byte, out_byte, position, run_last, status,
                 output ready);
endinterface

interface cxf_cfg_if;
    logic                valid;
    logic                ready;
    cxf_pkg::t_cfg_idx   index;
    logic [63:0]         data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/cxf_cfg.sv]
// Configuration register file of the codec.
module cxf_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  cxf_pkg::t_cfg_idx i_index,
    input  logic [63:0]       i_data,
    output cxf_pkg::t_cfg     o_cfg
);
    import cxf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic      <= '0;
            r_cfg.key        <= '0;
            r_cfg.key_length <= '0;
            r_cfg.capacity   <= CAPACITY_RESET;
        end else if (i_valid) begin
            unique case (i_index)
                CFG_MAGIC:    r_cfg.magic           <= i_data[15:0];
                CFG_KEY_LOW:  r_cfg.key[7:0]        <= i_data;
                CFG_KEY_HIGH: r_cfg.key[15:8]       <= i_data;
                CFG_KEY_LEN:  r_cfg.key_length      <= i_data[KLEN_W-1:0];
                CFG_CAPACITY: r_cfg.capacity        <= i_data[CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/cxf_frame.sv]
// Per-byte frame state: Fletcher sums, key walk, header checks, result bundle.
module cxf_frame #(
    parameter int MAX_FRAME = 4096,
    parameter int KEY_MAX   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_mode,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    input  cxf_pkg::t_cfg    i_cfg,
    output cxf_pkg::t_bundle o_bundle
);
    import cxf_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 6);
    localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
    localparam logic [CNT_W-1:0]  CNT_SAT = CNT_W'(MAX_FRAME + 5);
    localparam logic [CMP_W-1:0]  FRAME_LIM = CMP_W'(MAX_FRAME);
    localparam logic [KLEN_W-1:0] KL_MAX = KLEN_W'(KEY_MAX);
    localparam logic [CNT_W-1:0]  HDR_LEN = CNT_W'(4);

    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_sum_lo;
    logic [7:0]       r_sum_hi;
    logic [3:0]       r_key_idx;
    logic [15:0]      r_cks;
    logic             r_magic_bad;
    logic             r_mode;

    logic             start, cur_mode, walk, key_on, over_enc, over_dec;
    logic [KLEN_W-1:0] kl, ki_inc;
    logic [3:0]       ki_b, ki_w, n_key_idx;
    logic [7:0]       key_w, key0, key1, xb, fl_in, sum_lo_b, sum_hi_b, lo_new, hi_new;
    logic [8:0]       s1, s2;
    logic [15:0]      cks_b, n_cks;
    logic             bad_b, n_bad;
    logic [CNT_W-1:0] n_count;
    logic [CMP_W-1:0] idx_w, len_w, cap_w;
    t_status          dec_status;

    always_comb begin
        start    = (r_count == '0);
        cur_mode = start ? i_mode : r_mode;
        kl       = (i_cfg.key_length > KL_MAX) ? KL_MAX : i_cfg.key_length;
        key_on   = (kl != '0);
        sum_lo_b = start ? 8'd0 : r_sum_lo;
        sum_hi_b = start ? 8'd0 : r_sum_hi;
        cks_b    = start ? 16'd0 : r_cks;
        bad_b    = start ? 1'b0 : r_magic_bad;
        ki_b     = start ? ((kl > KLEN_W'(2)) ? 4'd2 : 4'd0) : r_key_idx;

        ki_w     = ({1'b0, ki_b} >= kl) ? 4'd0 : ki_b;
        key_w    = key_on ? i_cfg.key[ki_w] : 8'd0;
        ki_inc   = {1'b0, ki_w} + KLEN_W'(1);
        key0     = key_on ? i_cfg.key[0] : 8'd0;
        key1     = !key_on ? 8'd0 : ((kl == KLEN_W'(1)) ? i_cfg.key[0] : i_cfg.key[1]);

        walk     = !cur_mode || (r_count >= HDR_LEN);
        n_key_idx = ki_b;
        if (walk && key_on) begin
            n_key_idx = (ki_inc >= kl) ? 4'd0 : ki_inc[3:0];
        end

        xb    = i_data_byte ^ key_w;
        fl_in = cur_mode ? xb : i_data_byte;
        s1     = {1'b0, sum_lo_b} + {1'b0, fl_in};
        lo_new = (s1 >= FLETCHER_MOD) ? 8'(s1 - FLETCHER_MOD) : s1[7:0];
        s2     = {1'b0, sum_hi_b} + {1'b0, lo_new};
        hi_new = (s2 >= FLETCHER_MOD) ? 8'(s2 - FLETCHER_MOD) : s2[7:0];

        n_count = (r_count < CNT_SAT) ? r_count + CNT_W'(1) : r_count;
        idx_w   = CMP_W'(r_count);
        len_w   = CMP_W'(n_count);
        cap_w   = CMP_W'(i_cfg.capacity);
        over_enc = ((len_w + CMP_W'(4)) > cap_w) || ((len_w + CMP_W'(4)) > FRAME_LIM);
        over_dec = ((len_w - CMP_W'(4)) > cap_w) || (len_w > FRAME_LIM);

        n_bad = bad_b;
        n_cks = cks_b;
        if (cur_mode && !walk) begin
            unique case (r_count[1:0])
                2'd0: n_bad = bad_b | (i_data_byte != i_cfg.magic[15:8]);
                2'd1: n_bad = bad_b | (i_data_byte != i_cfg.magic[7:0]);
                2'd2: n_cks = {i_data_byte ^ key0, cks_b[7:0]};
                default: n_cks = {cks_b[15:8], i_data_byte ^ key1};
            endcase
        end

        priority if (bad_b) begin
            dec_status = ST_MAGIC;
        end else if (over_dec) begin
            dec_status = ST_OVER;
        end else if ({hi_new, lo_new} != cks_b) begin
            dec_status = ST_CHECKSUM;
        end else begin
            dec_status = ST_OK;
        end

        o_bundle = '0;
        if (!cur_mode) begin
            o_bundle.valid            = 1'b1;
            o_bundle.first.has_byte   = 1'b1;
            o_bundle.first.out_byte   = xb;
            o_bundle.first.position   = POS_W'(idx_w + CMP_W'(4));
            o_bundle.tail             = i_last_byte;
            o_bundle.tail_bytes[0]    = i_cfg.magic[15:8];
            o_bundle.tail_bytes[1]    = i_cfg.magic[7:0];
            o_bundle.tail_bytes[2]    = hi_new ^ key0;
            o_bundle.tail_bytes[3]    = lo_new ^ key1;
            o_bundle.tail_status      = over_enc ? ST_OVER : ST_OK;
        end else if (!walk) begin
            o_bundle.valid            = i_last_byte;
            o_bundle.first.run_last   = 1'b1;
            o_bundle.first.status     = ST_SHORT;
        end else begin
            o_bundle.valid            = 1'b1;
            o_bundle.first.has_byte   = 1'b1;
            o_bundle.first.out_byte   = xb;
            o_bundle.first.position   = POS_W'(idx_w - CMP_W'(4));
            o_bundle.first.run_last   = i_last_byte;
            o_bundle.first.status     = i_last_byte ? dec_status : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum_lo    <= '0;
            r_sum_hi    <= '0;
            r_key_idx   <= '0;
            r_cks       <= '0;
            r_magic_bad <= 1'b0;
            r_mode      <= 1'b0;
        end else if (i_fire) begin
            r_count     <= i_last_byte ? '0 : n_count;
            r_mode      <= cur_mode;
            r_sum_lo    <= walk ? lo_new : sum_lo_b;
            r_sum_hi    <= walk ? hi_new : sum_hi_b;
            r_key_idx   <= n_key_idx;
            r_cks       <= n_cks;
            r_magic_bad <= n_bad;
        end
    end

endmodule

[hw/rtl/cxf_out.sv]
// Result register: holds one bundle and sends its results one per transfer.
module cxf_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  cxf_pkg::t_bundle i_bundle,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_valid,
    output cxf_pkg::t_result o_result
);
    import cxf_pkg::*;
    `include "checksummed_xor_frame_codec_core_macros.svh"

    localparam logic [2:0] PH_FIRST = 3'd0;
    localparam logic [2:0] PH_LAST  = 3'd4;

    logic            r_valid;
    logic [2:0]      r_phase;
    t_result         r_first;
    logic            r_tail;
    logic [3:0][7:0] r_tail_bytes;
    t_status         r_tail_status;

    logic       done;
    logic [1:0] tsel;

    always_comb begin
        done = r_valid && i_out_ready &&
               ((r_phase == PH_LAST) || ((r_phase == PH_FIRST) && !r_tail));
        o_in_ready = !r_valid || done;
        o_valid    = r_valid;
        tsel       = 2'(r_phase - 3'd1);
        if (r_phase == PH_FIRST) begin
            o_result = r_first;
        end else begin
            o_result.has_byte = 1'b1;
            o_result.out_byte = r_tail_bytes[tsel];
            o_result.position = POS_W'(tsel);
            o_result.run_last = (r_phase == PH_LAST);
            o_result.status   = (r_phase == PH_LAST) ? r_tail_status : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= PH_FIRST;
        end else if (i_fire) begin
            r_valid <= i_bundle.valid;
            r_phase <= PH_FIRST;
        end else if (done) begin
            r_valid <= 1'b0;
        end else if (r_valid && i_out_ready) begin
            r_phase <= r_phase + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_first       <= i_bundle.first;
            r_tail        <= i_bundle.tail;
            r_tail_bytes  <= i_bundle.tail_bytes;
            r_tail_status <= i_bundle.tail_status;
        end
    end

    `CXF_ASSERT_IMP(a_tail_phase, i_clk, i_rst_n, r_valid && (r_phase != PH_FIRST), r_tail)
    `CXF_ASSERT_IMP(a_no_byte_short, i_clk, i_rst_n, r_valid && !o_result.has_byte, o_result.run_last && (o_result.status == ST_SHORT))
    `CXF_ASSERT_NEXT(a_phase_step, i_clk, i_rst_n, r_valid && i_out_ready && !done, r_valid && (r_phase == $past(r_phase) + 3'd1))

endmodule

[hw/rtl/checksummed_xor_frame_codec_core.sv]
// Top level of the checksummed XOR frame codec.
// A byte's first result is registered: valid in the cycle after its input transfer.
// Takes one byte per cycle while the output is ready; an encode last byte yields
// 5 results, sent one per transfer; input is held off until the last is taken.
// Reset clears frame state and restores register defaults (capacity 4096).
module checksummed_xor_frame_codec_core #(
    parameter int MAX_FRAME = 4096,
    parameter int KEY_MAX   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cxf_in_if.sink           i_in,
    cxf_out_if.source        o_out,
    cxf_cfg_if.sink          i_cfg
);
    import cxf_pkg::*;

    t_cfg    cfg;
    t_bundle bundle;
    t_result result;
    logic    in_ready, fire;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign fire        = i_in.valid && in_ready;

    cxf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    cxf_frame #(
        .MAX_FRAME (MAX_FRAME),
        .KEY_MAX   (KEY_MAX)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_mode      (i_in.mode),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .i_cfg       (cfg),
        .o_bundle    (bundle)
    );

    cxf_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_bundle    (bundle),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_valid     (o_out.valid),
        .o_result    (result)
    );

    assign o_out.has_byte = result.has_byte;
    assign o_out.out_byte = result.out_byte;
    assign o_out.position = result.position;
    assign o_out.run_last = result.run_last;
    assign o_out.status   = result.status;

endmodule

[test/testbench.sv]
// Self-checking testbench for the checksummed XOR frame codec core.
module testbench;
    import cxf_pkg::*;

    localparam int MAX_FRAME      = 4096;
    localparam int KEY_MAX        = 16;
    localparam int RANDOM_ITEMS   = 64;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef logic [7:0] t_byte_q[$];

    logic i_clk = 1'b0;
    logic i_rst_n;

    cxf_in_if  in_ch();
    cxf_out_if out_ch();
    cxf_cfg_if cfg_ch();

    checksummed_xor_frame_codec_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // register shadow
    logic [15:0]      cfg_magic;
    logic [15:0][7:0] cfg_key;
    logic [4:0]       cfg_key_len;
    logic [12:0]      cfg_cap;

    // frame state shadow
    int          bytes_in_frame;
    int          fl_low;
    int          fl_high;
    int          key_pos;
    logic [15:0] rx_checksum;
    logic        magic_bad;
    logic        frame_dir;

    t_result results_due[$];
    t_result due_head;

    logic quiet    = 1'b0;
    int   hold_req = 0;
    int   hold_ack = 0;
    int   hold_left = 0;

    int mismatch_count = 0;
    int result_total   = 0;
    int byte_total     = 0;
    int frames_sent    = 0;
    int settings_count = 0;
    int dead_cycles    = 0;

    function automatic int key_len_in_use();
        return (cfg_key_len > KEY_MAX) ? KEY_MAX : int'(cfg_key_len);
    endfunction

    function automatic logic [7:0] key_mod(input int idx);
        int kl;
        kl = key_len_in_use();
        if (kl == 0) return 8'h00;
        return cfg_key[idx % kl];
    endfunction

    function automatic logic [7:0] next_key_byte();
        int kl;
        logic [7:0] k;
        kl = key_len_in_use();
        if (kl == 0) return 8'h00;
        if (key_pos >= kl) key_pos = 0;
        k = cfg_key[key_pos];
        key_pos++;
        if (key_pos >= kl) key_pos = 0;
        return k;
    endfunction

    function automatic void fletcher_add(input logic [7:0] v);
        fl_low  = (fl_low + v) % int'(FLETCHER_MOD);
        fl_high = (fl_high + fl_low) % int'(FLETCHER_MOD);
    endfunction

    function automatic void push_result(input logic has, input logic [7:0] value,
                                        input logic [POS_W-1:0] pos, input logic last,
                                        input t_status st);
        t_result r;
        r.has_byte = has;
        r.out_byte = value;
        r.position = pos;
        r.run_last = last;
        r.status   = st;
        results_due.push_back(r);
    endfunction

    function automatic void predict_codec_output(input logic m, input logic [7:0] b,
                                                 input logic last);
        int idx;
        int len;
        int kl;
        logic [7:0] c;
        t_status st;
        if (bytes_in_frame == 0) begin
            kl          = key_len_in_use();
            frame_dir   = m;
            fl_low      = 0;
            fl_high     = 0;
            magic_bad   = 1'b0;
            rx_checksum = '0;
            key_pos     = (kl != 0) ? (2 % kl) : 0;
        end
        idx = bytes_in_frame;
        if (bytes_in_frame < MAX_FRAME + 5) bytes_in_frame++;
        len = bytes_in_frame;
        if (frame_dir == MODE_ENCODE) begin
            c = b ^ next_key_byte();
            fletcher_add(b);
            push_result(1'b1, c, POS_W'(idx + 4), 1'b0, ST_OK);
            if (last) begin
                st = (len + 4 > cfg_cap || len + 4 > MAX_FRAME) ? ST_OVER : ST_OK;
                push_result(1'b1, cfg_magic[15:8], POS_W'(0), 1'b0, ST_OK);
                push_result(1'b1, cfg_magic[7:0], POS_W'(1), 1'b0, ST_OK);
                push_result(1'b1, 8'(fl_high) ^ key_mod(0), POS_W'(2), 1'b0, ST_OK);
                push_result(1'b1, 8'(fl_low) ^ key_mod(1), POS_W'(3), 1'b1, st);
            end
        end else if (idx < 4) begin
            case (idx)
                0: if (b != cfg_magic[15:8]) magic_bad = 1'b1;
                1: if (b != cfg_magic[7:0]) magic_bad = 1'b1;
                2: rx_checksum[15:8] = b ^ key_mod(0);
                default: rx_checksum[7:0] = b ^ key_mod(1);
            endcase
            if (last) push_result(1'b0, 8'h00, POS_W'(0), 1'b1, ST_SHORT);
        end else begin
            c = b ^ next_key_byte();
            fletcher_add(c);
            st = ST_OK;
            if (last) begin
                if (magic_bad)
                    st = ST_MAGIC;
                else if (len - 4 > cfg_cap || len > MAX_FRAME)
                    st = ST_OVER;
                else if ({8'(fl_high), 8'(fl_low)} != rx_checksum)
                    st = ST_CHECKSUM;
            end
            push_result(1'b1, c, POS_W'(idx - 4), last, st);
        end
        if (last) bytes_in_frame = 0;
    endfunction

    // wire frame for a payload under the current key and magic
    function automatic void build_frame(input t_byte_q payload, output t_byte_q frame);
        int lo;
        int hi;
        lo = 0;
        hi = 0;
        foreach (payload[j]) begin
            lo = (lo + payload[j]) % int'(FLETCHER_MOD);
            hi = (hi + lo) % int'(FLETCHER_MOD);
        end
        frame = {};
        frame.push_back(cfg_magic[15:8]);
        frame.push_back(cfg_magic[7:0]);
        frame.push_back(8'(hi) ^ key_mod(0));
        frame.push_back(8'(lo) ^ key_mod(1));
        foreach (payload[j]) frame.push_back(payload[j] ^ key_mod(j + 2));
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic logic [63:0] rand_key_word();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [63:0] value);
        logic took;
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do begin
            @(negedge i_clk);
            took = cfg_ch.ready;
            @(posedge i_clk);
        end while (!took);
        case (idx)
            CFG_MAGIC:    cfg_magic = value[15:0];
            CFG_KEY_LOW:  cfg_key[7:0] = value;
            CFG_KEY_HIGH: cfg_key[15:8] = value;
            CFG_KEY_LEN:  cfg_key_len = value[4:0];
            CFG_CAPACITY: cfg_cap = value[12:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        settings_count++;
    endtask

    task automatic send_byte(input logic m, input logic [7:0] b, input logic last);
        logic took;
        while (!quiet && $urandom_range(99) < 14) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= m;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        do begin
            @(negedge i_clk);
            took = in_ch.ready;
            if (took) predict_codec_output(m, b, last);
            @(posedge i_clk);
        end while (!took);
        byte_total++;
    endtask

    // only the first byte's mode counts; later ones are random
    task automatic send_frame(input logic m, input t_byte_q stream);
        for (int i = 0; i < stream.size(); i++)
            send_byte((i == 0) ? m : logic'($urandom_range(1)), stream[i],
                      i == stream.size() - 1);
        frames_sent++;
    endtask

    task automatic test_reset_defaults();
        t_byte_q payload;
        payload = {8'h00, 8'hFF};
        send_frame(MODE_ENCODE, payload);
        wait_idle();
    endtask

    task automatic test_extreme_settings();
        t_byte_q payload;
        cfg_write(CFG_MAGIC, 64'hFFFF);
        cfg_write(CFG_KEY_LOW, '1);
        cfg_write(CFG_KEY_HIGH, '1);
        cfg_write(CFG_KEY_LEN, 64'd16);
        cfg_write(CFG_CAPACITY, 64'd4096);
        payload = {8'hFF, 8'h00};
        send_frame(MODE_ENCODE, payload);
        wait_idle();
    endtask

    task automatic test_decode_status();
        t_byte_q payload;
        t_byte_q frame;
        t_byte_q single;
        cfg_write(CFG_MAGIC, 64'hA55A);
        cfg_write(CFG_KEY_LOW, {$urandom(), $urandom()});
        cfg_write(CFG_KEY_LEN, 64'd2);
        payload = {8'hFF};
        build_frame(payload, frame);
        send_frame(MODE_DECODE, frame);
        single = {frame[0]};
        send_frame(MODE_DECODE, single);
        payload = {};
        build_frame(payload, frame);
        frame[1] = frame[1] ^ 8'h01;
        send_frame(MODE_DECODE, frame);
        cfg_write(CFG_CAPACITY, 64'd0);
        payload = {8'hFF};
        build_frame(payload, frame);
        frame[0] = frame[0] ^ 8'h80;
        send_frame(MODE_DECODE, frame);
        build_frame(payload, frame);
        frame[3] = frame[3] ^ 8'h01;
        send_frame(MODE_DECODE, frame);
        single = {8'h5A};
        send_frame(MODE_ENCODE, single);
        cfg_write(CFG_CAPACITY, 64'd4096);
        send_frame(MODE_DECODE, frame);
        wait_idle();
    endtask

    // key length shrinks below the walking index, then goes above the maximum
    task automatic test_key_change();
        cfg_write(CFG_KEY_HIGH, {$urandom(), $urandom()});
        cfg_write(CFG_KEY_LEN, 64'd16);
        send_byte(MODE_ENCODE, 8'h11, 1'b0);
        send_byte(MODE_DECODE, 8'h22, 1'b0);
        cfg_write(CFG_KEY_LEN, 64'd3);
        send_byte(MODE_ENCODE, 8'h33, 1'b0);
        cfg_write(CFG_KEY_LEN, 64'd31);
        send_byte(MODE_ENCODE, 8'h44, 1'b1);
        frames_sent++;
        wait_idle();
    endtask

    task automatic test_output_stall();
        t_byte_q payload;
        quiet    <= 1'b1;
        hold_req <= hold_req + 1;
        repeat (6) begin
            payload = {};
            repeat (5) payload.push_back(8'($urandom()));
            send_frame(MODE_ENCODE, payload);
        end
        wait_idle();
        quiet <= 1'b0;
    endtask

    task automatic random_settings();
        logic [63:0] klen;
        logic [63:0] cap;
        case ($urandom_range(5))
            0: klen = 0;
            1: klen = 1;
            2: klen = 16;
            3: klen = 17 + $urandom_range(14);
            default: klen = $urandom_range(31);
        endcase
        case ($urandom_range(3))
            0: cap = 0;
            1: cap = 4096;
            2: cap = $urandom_range(16);
            default: cap = $urandom_range(4096);
        endcase
        case ($urandom_range(3))
            0: cfg_write(CFG_MAGIC, 64'h0000);
            1: cfg_write(CFG_MAGIC, 64'hFFFF);
            default: cfg_write(CFG_MAGIC, 64'($urandom_range(16'hFFFF)));
        endcase
        cfg_write(CFG_KEY_LOW, rand_key_word());
        cfg_write(CFG_KEY_HIGH, rand_key_word());
        cfg_write(CFG_KEY_LEN, klen);
        cfg_write(CFG_CAPACITY, cap);
    endtask

    task automatic random_frame();
        t_byte_q payload;
        t_byte_q frame;
        int kind;
        int pick;
        int cut;
        kind    = $urandom_range(99);
        payload = {};
        repeat ($urandom_range(12)) payload.push_back(8'($urandom()));
        if (kind < 40) begin
            if (payload.size() == 0) payload.push_back(8'($urandom()));
            send_frame(MODE_ENCODE, payload);
        end else begin
            build_frame(payload, frame);
            if (kind >= 80) begin
                case ($urandom_range(3))
                    0: begin
                        pick = $urandom_range(frame.size() - 1);
                        frame[pick] = frame[pick] ^ 8'(1 << $urandom_range(7));
                    end
                    1: begin
                        cut = $urandom_range(1, 4);
                        while (frame.size() > cut) void'(frame.pop_back());
                    end
                    2: foreach (frame[i]) frame[i] = 8'($urandom());
                    default: begin
                        pick = $urandom_range(1);
                        frame[pick] = frame[pick] ^ 8'hFF;
                    end
                endcase
            end
            send_frame(MODE_DECODE, frame);
        end
    endtask

    task automatic test_random_traffic();
        int start;
        start = byte_total;
        quiet <= 1'b1;
        while (byte_total - start < RANDOM_ITEMS) begin
            if (byte_total - start >= 40) quiet <= 1'b0;
            random_settings();
            repeat ($urandom_range(2, 5)) random_frame();
            wait_idle();
        end
        quiet <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            out_ch.ready <= 1'b0;
            hold_ack     <= hold_req;
            hold_left    <= HOLD_CYCLES;
        end else begin
            out_ch.ready <= quiet || ($urandom_range(99) >= 14);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            result_total++;
            if (results_due.size() == 0) begin
                $error("unexpected result: out_byte 0x%0h position %0d",
                       out_ch.out_byte, out_ch.position);
                mismatch_count++;
            end else begin
                due_head = results_due.pop_front();
                check_field("has_byte", 32'(due_head.has_byte), 32'(out_ch.has_byte));
                check_field("out_byte", 32'(due_head.out_byte), 32'(out_ch.out_byte));
                check_field("position", 32'(due_head.position), 32'(out_ch.position));
                check_field("run_last", 32'(due_head.run_last), 32'(out_ch.run_last));
                check_field("status", 32'(due_head.status), 32'(out_ch.status));
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            dead_cycles = 0;
        end else if (dead_cycles >= WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles, %0d results outstanding",
                   dead_cycles, results_due.size());
            $display("Verification failed");
            $finish;
        end else begin
            dead_cycles++;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.mode      <= MODE_ENCODE;
        in_ch.data_byte <= 8'h00;
        in_ch.last_byte <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_MAGIC;
        cfg_ch.data     <= '0;
        cfg_magic      = '0;
        cfg_key        = '0;
        cfg_key_len    = '0;
        cfg_cap        = CAPACITY_RESET;
        bytes_in_frame = 0;
        fl_low         = 0;
        fl_high        = 0;
        key_pos        = 0;
        rx_checksum    = '0;
        magic_bad      = 1'b0;
        frame_dir      = MODE_ENCODE;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extreme_settings();
        test_decode_status();
        test_key_change();
        test_output_stall();
        test_random_traffic();

        wait_idle();
        $display("Sent %0d bytes in %0d frames over %0d register writes; %0d results checked.",
                 byte_total, frames_sent, settings_count, result_total);
        $display("Encode, decode, every status, key wrap and output stall done.");
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[checksummed_xor_frame_codec_core.f]
+incdir+hw/rtl
hw/rtl/cxf_pkg.sv
hw/rtl/cxf_if.sv
hw/rtl/cxf_cfg.sv
hw/rtl/cxf_frame.sv
hw/rtl/cxf_out.sv
hw/rtl/checksummed_xor_frame_codec_core.sv
test/testbench.sv
